[rtl/core/mfrb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mfrb_pkg;

    localparam int LINES  = 16;
    localparam int LINE_W = 4;
    localparam int COL_W  = 11;
    localparam int ROW_W  = 13;
    localparam int PIX_W  = 8;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_WINDOW = 2'd2;

    typedef struct packed {
        logic [COL_W-1:0] width;
        logic [ROW_W-1:0] height;
        logic [2:0]       half;
        logic [6:0]       target;
    } t_geom;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             eol;
        logic             eof;
    } t_job;

    typedef struct packed {
        logic              en;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
        logic [PIX_W-1:0]  data;
    } t_wr;

endpackage
`default_nettype wire

[rtl/core/mfrb_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface mfrb_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] pixel_value;
    modport source (output valid, req_type, pixel_value, input ready);
    modport sink   (input valid, req_type, pixel_value, output ready);
endinterface

interface mfrb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_pixel;
    logic       end_of_line;
    logic       end_of_frame;
    modport source (output valid, out_pixel, end_of_line, end_of_frame, input ready);
    modport sink   (input valid, out_pixel, end_of_line, end_of_frame, output ready);
endinterface
`default_nettype wire

[rtl/core/mfrb_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module mfrb_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    mfrb_in_if.sink            i_in,
    input  wire mfrb_pkg::t_geom i_geom,
    input  wire logic          i_restart,
    input  wire logic          i_full,
    input  wire logic          i_back_idle,
    output mfrb_pkg::t_wr      o_wr,
    output logic               o_push,
    output mfrb_pkg::t_job     o_job
);
    import mfrb_pkg::*;

    logic [COL_W-1:0] r_in_col, n_in_col, r_out_col, n_out_col;
    logic [ROW_W-1:0] r_in_row, n_in_row, r_out_row, n_out_row;
    logic             r_wait, n_wait;
    logic             accept, store, due, eol, eof;
    logic [COL_W-1:0] post_col, wm1, cc;
    logic [ROW_W-1:0] post_row, hm1, rr;
    logic [ROW_W:0]   rr_sum;
    logic [COL_W:0]   cc_sum;

    assign i_in.ready = !i_full && !r_wait;
    assign accept     = i_in.valid && i_in.ready;
    assign store      = accept && !i_in.req_type && (r_in_row < i_geom.height);
    assign wm1        = i_geom.width - 1'b1;
    assign hm1        = i_geom.height - 1'b1;

    always_comb begin
        post_col = r_in_col;
        post_row = r_in_row;
        if (store) begin
            if (r_in_col + 1'b1 >= i_geom.width) begin
                post_col = '0;
                post_row = r_in_row + 1'b1;
            end else begin
                post_col = r_in_col + 1'b1;
            end
        end
    end

    // Last input position that the window around the next output needs.
    assign rr_sum = {1'b0, r_out_row} + (ROW_W+1)'(i_geom.half);
    assign cc_sum = {1'b0, r_out_col} + (COL_W+1)'(i_geom.half);
    assign rr     = (rr_sum > {1'b0, hm1}) ? hm1 : rr_sum[ROW_W-1:0];
    assign cc     = (cc_sum > {1'b0, wm1}) ? wm1 : cc_sum[COL_W-1:0];
    assign due    = accept && (r_out_row < i_geom.height)
                    && ((post_row > rr) || ((post_row == rr) && (post_col > cc)));
    assign eol    = (r_out_col == wm1);
    assign eof    = eol && (r_out_row == hm1);

    always_comb begin
        n_in_col  = post_col;
        n_in_row  = post_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_wait    = r_wait;
        if (due) begin
            if (eol) begin
                n_out_col = '0;
                n_out_row = r_out_row + 1'b1;
            end else begin
                n_out_col = r_out_col + 1'b1;
            end
        end
        if (i_back_idle) begin
            n_wait = 1'b0;
        end
        // A new frame may overwrite the line store only once the back end has read it all.
        if (due && eof) begin
            n_wait = 1'b1;
        end
        if (i_restart || (due && eof)) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end
        if (i_restart) begin
            n_wait = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_wait    <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_wait    <= n_wait;
        end
    end

    assign o_wr.en   = store;
    assign o_wr.line = r_in_row[LINE_W-1:0];
    assign o_wr.col  = r_in_col;
    assign o_wr.data = i_in.pixel_value;
    assign o_push    = due;
    assign o_job.row = r_out_row;
    assign o_job.col = r_out_col;
    assign o_job.eol = eol;
    assign o_job.eof = eof;

`ifndef ASSERT_OFF
    a_wait_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait |-> !accept) else $error("transfer accepted while frame drains");
    a_eof_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (due && eof) |=> (r_out_row == '0 && r_out_col == '0 && r_in_row == '0))
        else $error("counters not cleared after frame end");
`endif

endmodule
`default_nettype wire

[rtl/core/mfrb_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module mfrb_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mfrb_pkg::t_job i_job,
    input  wire logic           i_pop,
    output mfrb_pkg::t_job      o_job,
    output logic                o_empty,
    output logic                o_full
);
    import mfrb_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QPTR_W:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("job queue underflow");
`endif

endmodule
`default_nettype wire

[rtl/core/mfrb_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module mfrb_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int TOP       = 7
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire mfrb_pkg::t_geom i_geom,
    input  wire mfrb_pkg::t_wr   i_wr,
    input  wire logic            i_empty,
    input  wire mfrb_pkg::t_job  i_job,
    output logic                 o_pop,
    output logic                 o_busy,
    output logic                 o_win_valid,
    output logic                 o_win_eol,
    output logic                 o_win_eof,
    output logic [7:0]           o_win [TOP*TOP]
);
    import mfrb_pkg::*;

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int HMAX = TOP / 2;

    logic              r_a_valid;
    t_job              r_a_job;
    logic [2:0]        r_a_phase;
    logic              a_start, a_last, a_bcast, take;
    logic [COL_W-1:0]  wm1, x;
    logic [ROW_W-1:0]  hm1;
    logic [COL_W:0]    col_sum;
    logic [LINE_W-1:0] sel [TOP];

    logic              r_b_valid, r_b_last, r_b_bcast, r_b_eol, r_b_eof;
    logic [LINE_W-1:0] r_b_sel [TOP];
    logic [7:0]        rd_all [LINES];
    logic [7:0]        column [TOP];

    logic [7:0]        r_win [TOP][TOP];
    logic              r_wv, r_weol, r_weof;

    assign wm1     = i_geom.width - 1'b1;
    assign hm1     = i_geom.height - 1'b1;
    assign a_start = (r_a_job.col == '0);
    // A line start loads the left edge into every column, then one column per cycle while the back end is enabled.
    assign a_bcast = a_start && (r_a_phase == '0);
    assign a_last  = !a_start || (r_a_phase == i_geom.half);
    assign take    = !r_a_valid || a_last;
    assign o_pop   = i_en && take && !i_empty;
    assign o_busy  = r_a_valid;
    assign col_sum = {1'b0, r_a_job.col} + (COL_W+1)'(i_geom.half);

    always_comb begin
        if (a_start) begin
            x = ({8'b0, r_a_phase} > wm1) ? wm1 : {8'b0, r_a_phase};
        end else begin
            x = (col_sum > {1'b0, wm1}) ? wm1 : col_sum[COL_W-1:0];
        end
    end

    always_comb begin
        logic signed [ROW_W+1:0] ys;
        for (int dy = 0; dy < TOP; dy++) begin
            ys = $signed({2'b00, r_a_job.row}) + (ROW_W+2)'(dy) - (ROW_W+2)'(HMAX);
            if (ys[ROW_W+1]) begin
                sel[dy] = '0;
            end else if (ys[ROW_W:0] > {1'b0, hm1}) begin
                sel[dy] = hm1[LINE_W-1:0];
            end else begin
                sel[dy] = ys[LINE_W-1:0];
            end
        end
    end

    for (genvar b = 0; b < LINES; b++) begin : g_bank
        logic [7:0] r_mem [MAX_WIDTH];
        logic [7:0] r_q;
        always_ff @(posedge i_clk) begin
            if (i_wr.en && (i_wr.line == LINE_W'(b))) begin
                r_mem[AW'(i_wr.col)] <= i_wr.data;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q <= r_mem[AW'(x)];
            end
        end
        assign rd_all[b] = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_phase <= '0;
            r_b_valid <= 1'b0;
            r_wv      <= 1'b0;
        end else if (i_en) begin
            if (take) begin
                r_a_valid <= !i_empty;
                r_a_phase <= '0;
            end else begin
                r_a_phase <= r_a_phase + 1'b1;
            end
            r_b_valid <= r_a_valid;
            r_wv      <= r_b_valid && r_b_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (take) begin
                r_a_job <= i_job;
            end
            r_b_last  <= a_last;
            r_b_bcast <= a_bcast;
            r_b_eol   <= r_a_job.eol;
            r_b_eof   <= r_a_job.eof;
            r_b_sel   <= sel;
            r_weol    <= r_b_eol;
            r_weof    <= r_b_eof;
        end
    end

    always_comb begin
        for (int dy = 0; dy < TOP; dy++) begin
            column[dy] = rd_all[r_b_sel[dy]];
        end
    end

    // The newest column enters at the right edge of the current window size.
    always_ff @(posedge i_clk) begin
        if (i_en && r_b_valid) begin
            for (int s = 0; s < TOP; s++) begin
                if (r_b_bcast || (4'(s) == 4'(HMAX) + {1'b0, i_geom.half})) begin
                    r_win[s] <= column;
                end else if (s < TOP - 1) begin
                    r_win[s] <= r_win[s+1];
                end
            end
        end
    end

    always_comb begin
        for (int dx = 0; dx < TOP; dx++) begin
            for (int dy = 0; dy < TOP; dy++) begin
                o_win[dy*TOP+dx] = r_win[dx][dy];
            end
        end
    end

    assign o_win_valid = r_wv;
    assign o_win_eol   = r_weol;
    assign o_win_eof   = r_weof;

`ifndef ASSERT_OFF
    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (r_a_phase <= i_geom.half)) else $error("fill phase overrun");
`endif

endmodule
`default_nettype wire

[rtl/core/mfrb_sort.sv]
`timescale 1ns / 1ps
`default_nettype none
module mfrb_sort #(
    parameter int TOP = 7
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire mfrb_pkg::t_geom i_geom,
    input  wire logic            i_win_valid,
    input  wire logic            i_win_eol,
    input  wire logic            i_win_eof,
    input  wire logic [7:0]      i_win [TOP*TOP],
    output logic                 o_en,
    mfrb_out_if.source           o_out
);
    import mfrb_pkg::*;

    localparam int N    = TOP * TOP;
    localparam int CW   = $clog2(N + 1);
    localparam int HMAX = TOP / 2;
    localparam int NST  = 8;

    logic [N-1:0] act;
    logic [7:0]   r_val  [NST][N];
    logic [N-1:0] r_mask [NST];
    logic [6:0]   r_tgt  [NST];
    logic [7:0]   r_pix  [NST];
    logic         r_vld  [NST];
    logic         r_eol  [NST];
    logic         r_eof  [NST];
    logic [N-1:0] n_mask [NST];
    logic [6:0]   n_tgt  [NST];
    logic [7:0]   n_pix  [NST];
    logic         r_o_valid, r_o_eol, r_o_eof;
    logic [7:0]   r_o_pix;

    for (genvar gy = 0; gy < TOP; gy++) begin : g_row
        for (genvar gx = 0; gx < TOP; gx++) begin : g_col
            localparam int DY = (gy > HMAX) ? gy - HMAX : HMAX - gy;
            localparam int DX = (gx > HMAX) ? gx - HMAX : HMAX - gx;
            assign act[gy*TOP+gx] = (3'(DY) <= i_geom.half) && (3'(DX) <= i_geom.half);
        end
    end

    // Radix select, one bit per stage from the top: count candidates with a zero
    // here and keep the half that holds the wanted rank.
    always_comb begin
        logic [CW-1:0] z;
        for (int j = 0; j < NST; j++) begin
            z = '0;
            for (int i = 0; i < N; i++) begin
                z = z + CW'(r_mask[j][i] & ~r_val[j][i][3'(NST-1-j)]);
            end
            n_pix[j] = r_pix[j];
            if (r_tgt[j] < 7'(z)) begin
                n_tgt[j] = r_tgt[j];
                for (int i = 0; i < N; i++) begin
                    n_mask[j][i] = r_mask[j][i] & ~r_val[j][i][3'(NST-1-j)];
                end
            end else begin
                n_tgt[j] = r_tgt[j] - 7'(z);
                n_pix[j][3'(NST-1-j)] = 1'b1;
                for (int i = 0; i < N; i++) begin
                    n_mask[j][i] = r_mask[j][i] & r_val[j][i][3'(NST-1-j)];
                end
            end
        end
    end

    assign o_en = !r_o_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NST; j++) begin
                r_vld[j] <= 1'b0;
            end
            r_o_valid <= 1'b0;
        end else if (o_en) begin
            r_vld[0] <= i_win_valid;
            for (int j = 1; j < NST; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
            r_o_valid <= r_vld[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_val[0]  <= i_win;
            r_mask[0] <= act;
            r_tgt[0]  <= i_geom.target;
            r_pix[0]  <= '0;
            r_eol[0]  <= i_win_eol;
            r_eof[0]  <= i_win_eof;
            for (int j = 1; j < NST; j++) begin
                r_val[j]  <= r_val[j-1];
                r_mask[j] <= n_mask[j-1];
                r_tgt[j]  <= n_tgt[j-1];
                r_pix[j]  <= n_pix[j-1];
                r_eol[j]  <= r_eol[j-1];
                r_eof[j]  <= r_eof[j-1];
            end
            r_o_pix <= n_pix[NST-1];
            r_o_eol <= r_eol[NST-1];
            r_o_eof <= r_eof[NST-1];
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.out_pixel    = r_o_pix;
    assign o_out.end_of_line  = r_o_eol;
    assign o_out.end_of_frame = r_o_eof;

endmodule
`default_nettype wire

[rtl/core/median_filter_replicate_border.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Payload                                   Transfer
// i_in      in   req_type, pixel_value                     valid & ready
// o_out     out  out_pixel, end_of_line, end_of_frame      valid & ready
// cfg       in   APB: 0 width, 4 height, 8 window size     psel & penable & pwrite
//
// One input item per cycle while ready is high; a result passes the job queue, fetch,
// window and sort registers. The first output of a line waits while the fetch fills the
// window, one line store read per cycle unless the output stalls; after the last output
// of a frame, input is held until the fetch has finished with the line store. A stalled
// output only stalls the back end; the front keeps taking items until the four-entry job
// queue fills. Reset is synchronous and active low; the line store is not cleared.
module median_filter_replicate_border #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 7
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    mfrb_in_if.sink          i_in,
    mfrb_out_if.source       o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mfrb_pkg::*;

    localparam int TOP = (MAX_WINDOW - 1) | 1;

    logic [COL_W-1:0] r_cfg_width;
    logic [ROW_W-1:0] r_cfg_height;
    logic [2:0]       r_cfg_window;
    logic             wr_cfg, restart;
    logic [COL_W-1:0] width_eff;
    logic [3:0]       kreq, ksize;
    logic [7:0]       ksq;
    t_geom            geom;
    t_wr              wr;
    t_job             push_job, head_job;
    logic             push, pop, q_empty, q_full, back_busy, en;
    logic             win_valid, win_eol, win_eof;
    logic [7:0]       win [TOP*TOP];

    assign pready = 1'b1;
    assign wr_cfg = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= COL_W'(256);
            r_cfg_height <= ROW_W'(256);
            r_cfg_window <= 3'd3;
        end else if (wr_cfg) begin
            unique case (paddr[3:2])
                REG_WIDTH:  r_cfg_width  <= pwdata[COL_W-1:0];
                REG_HEIGHT: r_cfg_height <= pwdata[ROW_W-1:0];
                REG_WINDOW: r_cfg_window <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    assign restart = wr_cfg && ((paddr[3:2] == REG_WIDTH) || (paddr[3:2] == REG_HEIGHT)
                                || (paddr[3:2] == REG_WINDOW));

    always_comb begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(r_cfg_width);
            REG_HEIGHT: prdata = 32'(r_cfg_height);
            REG_WINDOW: prdata = 32'(r_cfg_window);
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        if (r_cfg_width == '0) begin
            width_eff = COL_W'(1);
        end else if ({2'b00, r_cfg_width} > 13'(MAX_WIDTH)) begin
            width_eff = COL_W'(MAX_WIDTH);
        end else begin
            width_eff = r_cfg_width;
        end
    end

    assign geom.width  = width_eff;
    assign geom.height = (r_cfg_height == '0) ? ROW_W'(1) : r_cfg_height;
    assign kreq        = (r_cfg_window < 3'd3) ? 4'd3 : {1'b0, r_cfg_window | 3'b001};
    assign ksize       = (kreq > 4'(TOP)) ? 4'(TOP) : kreq;
    assign ksq         = 8'(ksize) * 8'(ksize);
    assign geom.half   = ksize[3:1];
    assign geom.target = ksq[7:1];

    mfrb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_geom      (geom),
        .i_restart   (restart),
        .i_full      (q_full),
        .i_back_idle (q_empty && !back_busy),
        .o_wr        (wr),
        .o_push      (push),
        .o_job       (push_job)
    );

    mfrb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    mfrb_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .TOP       (TOP)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_geom      (geom),
        .i_wr        (wr),
        .i_empty     (q_empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_busy      (back_busy),
        .o_win_valid (win_valid),
        .o_win_eol   (win_eol),
        .o_win_eof   (win_eof),
        .o_win       (win)
    );

    mfrb_sort #(
        .TOP (TOP)
    ) u_sort (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (geom),
        .i_win_valid (win_valid),
        .i_win_eol   (win_eol),
        .i_win_eof   (win_eof),
        .i_win       (win),
        .o_en        (en),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

[bench/median_filter_replicate_border_test.sv]
`timescale 1ns / 1ps

typedef struct {
    bit [7:0] pix;
    bit       eol;
    bit       eof;
} t_median_out;

class median_scoreboard;
    bit [7:0]    store[16*1024];
    int unsigned width_reg, height_reg, window_reg;
    int unsigned in_col, in_row, out_col, out_row;
    t_median_out awaited[$];
    int          errors;

    function new();
        width_reg = 256;
        height_reg = 256;
        window_reg = 3;
        errors = 0;
        restart();
    endfunction

    function void restart();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function int unsigned eff_width();
        if (width_reg == 0) return 1;
        return (width_reg > 1024) ? 1024 : width_reg;
    endfunction

    function int unsigned eff_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function int unsigned eff_window();
        int unsigned k;
        k = (window_reg < 3) ? 3 : (window_reg | 1);
        return (k > 7) ? 7 : k;
    endfunction

    function void configure(logic [1:0] idx, logic [31:0] value);
        case (idx)
            mfrb_pkg::REG_WIDTH:  width_reg  = value[10:0];
            mfrb_pkg::REG_HEIGHT: height_reg = value[12:0];
            mfrb_pkg::REG_WINDOW: window_reg = value[2:0];
            default: return;
        endcase
        restart();
    endfunction

    function bit frame_idle();
        return in_col == 0 && in_row == 0;
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    function bit [7:0] median_at(int unsigned k, int unsigned w, int unsigned h);
        int          cnt[256];
        int          y, x, half, acc;
        int unsigned target;
        half = k / 2;
        foreach (cnt[i]) cnt[i] = 0;
        for (int dy = 0; dy < k; dy++) begin
            y = int'(out_row) + dy - half;
            if (y < 0) y = 0;
            if (y > int'(h) - 1) y = h - 1;
            for (int dx = 0; dx < k; dx++) begin
                x = int'(out_col) + dx - half;
                if (x < 0) x = 0;
                if (x > int'(w) - 1) x = w - 1;
                cnt[store[(y % 16) * 1024 + x]]++;
            end
        end
        target = (k * k) / 2;
        acc = 0;
        for (int i = 0; i < 256; i++) begin
            acc += cnt[i];
            if (acc > target) return i[7:0];
        end
        return 8'd255;
    endfunction

    // Takes one accepted input transfer and queues the result it releases, if any.
    function void note_input(bit req_type, bit [7:0] pix);
        int unsigned w, h, k, rr, cc;
        t_median_out r;
        w = eff_width();
        h = eff_height();
        k = eff_window();
        if (!req_type && in_row < h) begin
            store[(in_row % 16) * 1024 + in_col] = pix;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        if (out_row >= h) return;
        rr = out_row + k / 2;
        if (rr > h - 1) rr = h - 1;
        cc = out_col + k / 2;
        if (cc > w - 1) cc = w - 1;
        if (!(in_row > rr || (in_row == rr && in_col > cc))) return;
        r.pix = median_at(k, w, h);
        r.eol = (out_col == w - 1);
        r.eof = r.eol && (out_row == h - 1);
        awaited = {awaited, r};
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        if (r.eof) restart();
    endfunction

    function void check(bit [7:0] pix, bit eol, bit eof);
        t_median_out e;
        if (awaited.size() == 0) begin
            $display("%0t: unexpected result pixel %0d eol %0d eof %0d", $time, pix, eol, eof);
            errors++;
            return;
        end
        e = awaited.pop_front();
        if (e.pix !== pix || e.eol !== eol || e.eof !== eof) begin
            $display("%0t: mismatch, expected pixel %0d eol %0d eof %0d, got %0d %0d %0d",
                     $time, e.pix, e.eol, e.eof, pix, eol, eof);
            errors++;
        end
    endfunction
endclass

module median_filter_replicate_border_test;
    // An index beyond the register list, which the block ignores.
    localparam logic [1:0] REG_SPARE = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mfrb_in_if  in_ch ();
    mfrb_out_if out_ch ();

    median_filter_replicate_border i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    median_scoreboard sb = new();
    int send_idle_pct;
    int stall_pct;
    int hold_off;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("median_filter_replicate_border test failed");
        $finish;
    end

    // Result side: check every transfer, then pick the ready for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check(out_ch.out_pixel, out_ch.end_of_line, out_ch.end_of_frame);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send(bit req_type, bit [7:0] pix);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.req_type    <= req_type;
        in_ch.pixel_value <= pix;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(req_type, pix);
    endtask

    // Lets every queued result arrive, then allows for work that releases nothing.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.configure(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(int unsigned w, int unsigned h, int unsigned k);
        apb_write(mfrb_pkg::REG_WIDTH, w);
        apb_write(mfrb_pkg::REG_HEIGHT, h);
        apb_write(mfrb_pkg::REG_WINDOW, k);
    endtask

    function automatic bit [7:0] pick_pixel();
        int r;
        r = $urandom_range(99);
        if (r < 8) return 8'd0;
        if (r < 16) return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    // Streams one frame, or half of one when aborted, with stray early drain ticks, then drains it out unless aborted.
    task automatic run_frame(bit abort);
        int unsigned total, stop;
        total = sb.eff_width() * sb.eff_height();
        stop = abort ? total / 2 : total;
        for (int unsigned n = 0; n < stop; n++) begin
            if ($urandom_range(99) < 6) send(1'b1, 8'($urandom_range(255)));
            send(1'b0, pick_pixel());
        end
        if (abort) begin
            settle();
            return;
        end
        while (!sb.frame_idle()) send($urandom_range(99) < 75, 8'($urandom_range(255)));
        settle();
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.req_type = 1'b0;
        in_ch.pixel_value = '0;
        out_ch.ready = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // Directed: tiny frames, a degenerate size, window settings 0, 1, 2, 6 and 7.
        set_frame(0, 0, 0);
        run_frame(0);
        set_frame(1, 1, 7);
        run_frame(0);
        set_frame(3, 3, 1);
        run_frame(0);
        set_frame(4, 2, 6);
        run_frame(0);
        set_frame(2, 3, 2);
        run_frame(0);
        apb_write(REG_SPARE, 32'hFFFF_FFFF);
        run_frame(0);

        // The widest line, with the output held off long enough to fill the block.
        set_frame(2047, 1, 5);
        hold_off = 400;
        run_frame(0);
        // A single column taller than the line store.
        set_frame(1, 24, 7);
        run_frame(0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 59; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 34; stall_pct = 34; end
            endcase
            for (int f = 0; f < 5; f++) begin
                if ($urandom_range(99) < 70)
                    set_frame($urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(0, 7));
                else
                    set_frame($urandom_range(7, 16), $urandom_range(1, 2), $urandom_range(0, 7));
                run_frame($urandom_range(99) < 12);
            end
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("median_filter_replicate_border test passed");
        else
            $display("median_filter_replicate_border test failed");
        $finish;
    end
endmodule
